### rtl/core/npc_pkg.sv
`timescale 1ns / 1ps

package npc_pkg;

  localparam int unsigned MAX_COLORS = 16;
  localparam int unsigned IDX_W      = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
  localparam int unsigned CFG_W      = 5;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned COMP_W     = 8;
  localparam int unsigned DIST_W     = 18;
  localparam int unsigned CMP_W      = ((IDX_W > CFG_W) ? IDX_W : CFG_W) + 1;

  localparam logic [DIST_W-1:0] DIST_START = DIST_W'(255 * 255 * 3 + 1);
  localparam logic [CFG_W-1:0]  CFG_RESET  = CFG_W'(2);

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
  } color_t;

  // one item moving down the cell row, carrying the best match so far
  typedef struct packed {
    logic              valid;
    cmd_e              cmd;
    logic [SLOT_W-1:0] slot;
    color_t            pix;
    logic [DIST_W-1:0] best_dist;
    logic [IDX_W-1:0]  best_idx;
    color_t            best_col;
  } token_t;

endpackage

### rtl/core/npc_cell.sv
`timescale 1ns / 1ps

module npc_cell
  import npc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  logic [IDX_W-1:0] cell_idx_i,
  input  logic [CFG_W-1:0] count_i,
  input  token_t           tok_i,
  output token_t           tok_o
);

  color_t              entry_q;
  logic                valid_q;
  token_t              tok_q;
  token_t              tok_d;
  logic                active;
  logic                wr_en;
  logic [COMP_W-1:0]   dr;
  logic [COMP_W-1:0]   dg;
  logic [COMP_W-1:0]   db;
  logic [2*COMP_W-1:0] sq_r;
  logic [2*COMP_W-1:0] sq_g;
  logic [2*COMP_W-1:0] sq_b;
  logic [DIST_W-1:0]   sq_dist;

  assign active = CMP_W'(cell_idx_i) < CMP_W'(count_i);
  assign wr_en  = advance_i && tok_i.valid && (tok_i.cmd == CMD_LOAD)
                  && (CMP_W'(tok_i.slot) == CMP_W'(cell_idx_i));

  assign dr = (tok_i.pix.red > entry_q.red) ? tok_i.pix.red - entry_q.red
                                            : entry_q.red - tok_i.pix.red;
  assign dg = (tok_i.pix.green > entry_q.green) ? tok_i.pix.green - entry_q.green
                                                : entry_q.green - tok_i.pix.green;
  assign db = (tok_i.pix.blue > entry_q.blue) ? tok_i.pix.blue - entry_q.blue
                                              : entry_q.blue - tok_i.pix.blue;

  assign sq_r    = dr * dr;
  assign sq_g    = dg * dg;
  assign sq_b    = db * db;
  assign sq_dist = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);

  always_comb begin
    tok_d = tok_i;
    // strict less-than keeps the lowest slot on ties
    if (tok_i.cmd == CMD_LOOKUP && active && sq_dist < tok_i.best_dist) begin
      tok_d.best_dist = sq_dist;
      tok_d.best_idx  = cell_idx_i;
      tok_d.best_col  = entry_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_q <= tok_i.pix;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      tok_q <= tok_d;
    end
  end

  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = valid_q;
  end

endmodule

### rtl/core/nearest_palette_color.sv
`timescale 1ns / 1ps

// Nearest palette color search. Palette loads (tuser = 0) and lookups (tuser = 1)
// enter a row of MAX_COLORS cells, one cell per palette slot, and move one cell
// per cycle unless the output stalls; loads travel the row too, so every item
// sees the palette exactly as the items before it left it. One item is accepted
// per cycle unless the output stalls. The first cell registers a lookup at the
// edge that accepts it, then the lookup steps through the remaining cells and the
// output register. A stall on the output freezes the whole row. Loads give no
// result. palette_size is to be written only while idle; this is not enforced.
module nearest_palette_color
  import npc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // [3:0] entry_index, [11:4] in_red, [19:12] in_green, [27:20] in_blue
  input  logic [31:0]      s_axis_tdata,
  // [0] cmd
  input  logic [0:0]       s_axis_tuser,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // [7:0] out_red, [15:8] out_green, [23:16] out_blue, [27:24] match_index
  output logic [31:0]      m_axis_tdata
);

  logic [CFG_W-1:0] size_q;
  logic [CFG_W-1:0] count;
  logic             advance;
  logic             out_valid_q;
  logic             out_valid_d;
  logic [31:0]      out_data_q;
  token_t           chain [MAX_COLORS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      size_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    count = size_q;
    if (size_q == '0) begin
      count = CFG_W'(1);
    end else if (CMP_W'(size_q) > CMP_W'(MAX_COLORS)) begin
      count = CFG_W'(MAX_COLORS);
    end
  end

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = advance;

  always_comb begin
    chain[0]           = '0;
    chain[0].valid     = s_axis_tvalid;
    chain[0].cmd       = cmd_e'(s_axis_tuser[0]);
    chain[0].slot      = s_axis_tdata[3:0];
    chain[0].pix.red   = s_axis_tdata[11:4];
    chain[0].pix.green = s_axis_tdata[19:12];
    chain[0].pix.blue  = s_axis_tdata[27:20];
    chain[0].best_dist = DIST_START;
  end

  for (genvar i = 0; i < MAX_COLORS; i++) begin : g_cell
    npc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .advance_i  (advance),
      .cell_idx_i (IDX_W'(i)),
      .count_i    (count),
      .tok_i      (chain[i]),
      .tok_o      (chain[i+1])
    );
  end

  assign out_valid_d = chain[MAX_COLORS].valid && (chain[MAX_COLORS].cmd == CMD_LOOKUP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && out_valid_d) begin
      out_data_q <= {4'b0000,
                     SLOT_W'(chain[MAX_COLORS].best_idx),
                     chain[MAX_COLORS].best_col.blue,
                     chain[MAX_COLORS].best_col.green,
                     chain[MAX_COLORS].best_col.red};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
